/* src/tbr_pkg.sv */
// Shared types, codes and the color palette of the tiled background renderer.
package tbr_pkg;

    typedef enum logic [1:0]
    {
        CMD_WRITE_RAM = 2'd0,
        CMD_LOAD_ROM  = 2'd1,
        CMD_RENDER    = 2'd2,
        CMD_UNUSED    = 2'd3
    } command_t;

    typedef enum logic [2:0]
    {
        CFG_DISPLAY_MODE   = 3'd0,
        CFG_DISPLAY_ENABLE = 3'd1,
        CFG_STACK_COLOR_0  = 3'd2,
        CFG_STACK_COLOR_1  = 3'd3,
        CFG_STACK_COLOR_2  = 3'd4,
        CFG_STACK_COLOR_3  = 3'd5,
        CFG_SPARE_6        = 3'd6,
        CFG_SPARE_7        = 3'd7
    } cfg_index_t;

    localparam int RAM_DEPTH = 512;
    localparam int RAM_AW    = 9;

    // One tile row waiting for or in the serializer.
    typedef struct packed
    {
        logic [3:0] fg;
        logic [3:0] bg;
        logic [4:0] col;
        logic       last;
        logic       en;
    } tile_job_t;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        unique case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0827ff;
            4'd2:    rgb = 24'hff3a06;
            4'd3:    rgb = 24'hcad565;
            4'd4:    rgb = 24'h017907;
            4'd5:    rgb = 24'h02a91b;
            4'd6:    rgb = 24'hfaeb25;
            4'd7:    rgb = 24'hfffcff;
            4'd8:    rgb = 24'ha8a9a9;
            4'd9:    rgb = 24'h5bccff;
            4'd10:   rgb = 24'hffa707;
            4'd11:   rgb = 24'h395801;
            4'd12:   rgb = 24'hff2c77;
            4'd13:   rgb = 24'hbf96ff;
            4'd14:   rgb = 24'h6dce2d;
            default: rgb = 24'hc9107e;
        endcase
        return rgb;
    endfunction

endpackage

/* src/tbr_card_mem.sv */
// Card bitmap memory: one write port, one read port with registered read data.
module tbr_card_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tbr_pixel_ser.sv */
// Pixel serializer: shifts one card byte out as one colored pixel per cycle while m_tready is high.
module tbr_pixel_ser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  tbr_pkg::tile_job_t job,
    input  logic [7:0]        bits,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tlast
);

    import tbr_pkg::*;

    logic      valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] bits_reg, bits_next;
    tile_job_t job_reg, job_next;
    logic      last_pix;
    logic      row_end;
    logic      load;
    logic [3:0] color_idx;

    assign last_pix   = job_reg.last && (idx_reg == 3'd6);
    assign row_end    = last_pix || (idx_reg == 3'd7);
    assign load_ready = !valid_reg || (m_tready && row_end);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        job_next   = job_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
            bits_next  = bits;
            job_next   = job;
        end
        else if (valid_reg && m_tready)
        begin
            if (row_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next  = idx_reg + 3'd1;
                bits_next = {bits_reg[6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        job_reg  <= job_next;
    end

    // Leftmost pixel sits in bit 7.
    assign color_idx = bits_reg[7] ? job_reg.fg : job_reg.bg;

    always_comb
    begin
        m_tvalid        = valid_reg;
        m_tdata[23:0]   = job_reg.en ? palette_rgb(color_idx) : 24'h000000;
        m_tdata[31:24]  = {job_reg.col, idx_reg};
        m_tlast         = last_pix;
    end

endmodule

/* src/tiled_background_renderer_top.sv */
// Top level of the tiled background renderer: request decode, stack state, card memories.
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready. s_tuser carries the command
//   (write card RAM, load card ROM, render one tile row). Writes go straight
//   into the card memories and produce no output. A render request reads one
//   card byte and emits 8 pixels on m_tvalid/m_tready/m_tdata, 7 for the last
//   column, with m_tlast on the final pixel of the last column.
//   A render request is registered in the fetch stage and then in the serializer
//   before its first pixel is valid. The serializer sends one pixel per cycle
//   while m_tready is high; writes complete as they are accepted.
//   One render request is buffered ahead of the serializer, so a new request
//   is taken while pixels of the previous one are still being sent.
//   When the receiver stalls, the current pixel holds and the buffer fills,
//   after which s_tready drops. Render requests with an unused command or a
//   column past the line end are dropped.
//   The user must write configuration through cfg_valid/cfg_ready only while idle; the block does not enforce it.
//   Reset clears the config registers and the stack position; card memory
//   contents are undefined until written.
module tiled_background_renderer_top #(
    parameter int TILES_PER_ROW = 20,
    parameter int ROM_DEPTH     = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [10:0] mem_address, [18:11] mem_data, [32:19] tile_word,
    // [39:33] scan_line, [44:40] tile_column, [47:45] zero
    input  logic [47:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [23:0] pixel_rgb, [31:24] pixel_x
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    import tbr_pkg::*;

    localparam int          ROM_AW    = $clog2(ROM_DEPTH);
    localparam logic [11:0] RomDepthW = 12'(ROM_DEPTH);
    localparam logic [5:0]  ColLimit  = 6'(TILES_PER_ROW);
    localparam logic [4:0]  LastCol   = 5'(TILES_PER_ROW - 1);

    // Bring an 11-bit byte address into the ROM range.
    function automatic logic [10:0] rom_wrap(input logic [10:0] a);
        logic [11:0] v;
        v = {1'b0, a};
        for (int i = 0; i < 3; i++)
        begin
            if (v >= RomDepthW)
            begin
                v = v - RomDepthW;
            end
        end
        return v[10:0];
    endfunction

    command_t    cmd;
    logic [10:0] mem_address;
    logic [7:0]  mem_data;
    logic [13:0] tile_word;
    logic [6:0]  scan_line;
    logic [4:0]  tile_column;
    logic [2:0]  card_row;

    assign cmd         = command_t'(s_tuser);
    assign mem_address = s_tdata[10:0];
    assign mem_data    = s_tdata[18:11];
    assign tile_word   = s_tdata[32:19];
    assign scan_line   = s_tdata[39:33];
    assign tile_column = s_tdata[44:40];
    assign card_row    = scan_line[2:0];

    logic in_acc;
    logic col_ok;
    logic is_last;
    logic render_acc;
    logic ram_we;
    logic rom_we;

    assign in_acc     = s_tvalid && s_tready;
    assign col_ok     = {1'b0, tile_column} < ColLimit;
    assign is_last    = tile_column == LastCol;
    assign render_acc = in_acc && (cmd == CMD_RENDER) && col_ok;
    assign ram_we     = in_acc && (cmd == CMD_WRITE_RAM);
    assign rom_we     = in_acc && (cmd == CMD_LOAD_ROM);

    // Configuration registers.
    logic       mode_reg, mode_next;
    logic       enable_reg, enable_next;
    logic [3:0] stack_color_reg [4];
    logic [3:0] stack_color_next [4];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next        = mode_reg;
        enable_next      = enable_reg;
        stack_color_next = stack_color_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DISPLAY_MODE:   mode_next           = cfg_data[0];
                CFG_DISPLAY_ENABLE: enable_next         = cfg_data[0];
                CFG_STACK_COLOR_0:  stack_color_next[0] = cfg_data;
                CFG_STACK_COLOR_1:  stack_color_next[1] = cfg_data;
                CFG_STACK_COLOR_2:  stack_color_next[2] = cfg_data;
                CFG_STACK_COLOR_3:  stack_color_next[3] = cfg_data;
                default:            mode_next           = mode_reg;
            endcase
        end
    end

    // Color stack position.
    logic [1:0] row_start_reg, row_start_next;
    logic [1:0] run_stack_reg, run_stack_next;
    logic [1:0] stack_base;
    logic [1:0] stack_adv;

    always_comb
    begin
        if (tile_column == 5'd0)
        begin
            stack_base = (scan_line == 7'd0) ? 2'd0 : row_start_reg;
        end
        else
        begin
            stack_base = run_stack_reg;
        end
        stack_adv = (!mode_reg && tile_word[13]) ? stack_base + 2'd1 : stack_base;

        row_start_next = row_start_reg;
        run_stack_next = run_stack_reg;
        if (render_acc && enable_reg)
        begin
            run_stack_next = stack_adv;
            // Commit at the last line of a card row; line zero restarts the frame.
            if (is_last && (card_row == 3'd7))
            begin
                row_start_next = stack_adv;
            end
            else if ((tile_column == 5'd0) && (scan_line == 7'd0))
            begin
                row_start_next = 2'd0;
            end
        end
    end

    // Card memory addressing.
    logic [RAM_AW-1:0] ram_raddr;
    logic [10:0]       rom_rbyte;
    logic [ROM_AW-1:0] rom_raddr;
    logic [ROM_AW-1:0] rom_waddr;
    logic [10:0]       rom_rwrap;
    logic [10:0]       rom_wwrap;
    logic [7:0]        ram_q;
    logic [7:0]        rom_q;

    assign ram_raddr = {tile_word[8:3], card_row};
    assign rom_rbyte = mode_reg ? {2'b00, tile_word[8:3], card_row}
                                : {tile_word[10:3], card_row};
    assign rom_rwrap = rom_wrap(rom_rbyte);
    assign rom_wwrap = rom_wrap(mem_address);
    assign rom_raddr = rom_rwrap[ROM_AW-1:0];
    assign rom_waddr = rom_wwrap[ROM_AW-1:0];

    tbr_card_mem #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_card_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (mem_address[RAM_AW-1:0]),
        .wdata (mem_data),
        .re    (render_acc),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    tbr_card_mem #(
        .DEPTH (ROM_DEPTH),
        .AW    (ROM_AW)
    ) u_card_rom (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_waddr),
        .wdata (mem_data),
        .re    (render_acc),
        .raddr (rom_raddr),
        .rdata (rom_q)
    );

    // Fetch stage: holds one render request while its card byte is read.
    logic      a_valid_reg, a_valid_next;
    tile_job_t a_job_reg, a_job_next;
    logic      a_src_ram_reg, a_src_ram_next;
    logic      ser_ready;
    logic      b_load;

    assign b_load   = a_valid_reg && ser_ready;
    assign s_tready = !a_valid_reg || b_load;

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        a_job_next     = a_job_reg;
        a_src_ram_next = a_src_ram_reg;
        if (render_acc)
        begin
            a_valid_next   = 1'b1;
            a_src_ram_next = tile_word[11];
            a_job_next.col  = tile_column;
            a_job_next.last = is_last;
            a_job_next.en   = enable_reg;
            if (mode_reg)
            begin
                a_job_next.fg = {1'b0, tile_word[2:0]};
                a_job_next.bg = {tile_word[12], tile_word[13], tile_word[10:9]};
            end
            else
            begin
                a_job_next.fg = {tile_word[12], tile_word[2:0]};
                a_job_next.bg = stack_color_reg[stack_base];
            end
        end
        else if (b_load)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            enable_reg      <= 1'b0;
            stack_color_reg <= '{4'd0, 4'd0, 4'd0, 4'd0};
            row_start_reg   <= 2'd0;
            run_stack_reg   <= 2'd0;
            a_valid_reg     <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            enable_reg      <= enable_next;
            stack_color_reg <= stack_color_next;
            row_start_reg   <= row_start_next;
            run_stack_reg   <= run_stack_next;
            a_valid_reg     <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_job_reg     <= a_job_next;
        a_src_ram_reg <= a_src_ram_next;
    end

    tbr_pixel_ser u_pixel_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (a_valid_reg),
        .load_ready (ser_ready),
        .job        (a_job_reg),
        .bits       (a_src_ram_reg ? ram_q : rom_q),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* src/tbr_checker.sv */
// Port-level checks on the pixel stream of the renderer, bound to the top level.
module tbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled pixel.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel changed");

    // Pixels of one tile row follow without a gap, x advancing by one.
    a_row_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast && (m_tdata[26:24] != 3'd7)
        |=> m_tvalid && (m_tdata[31:24] == $past(m_tdata[31:24]) + 8'd1))
        else $error("tile row pixels not contiguous");

    // The last tile of a line ends on its seventh pixel.
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[26:24] == 3'd6)
        else $error("last pixel at wrong position");

    // No output while in reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind tiled_background_renderer_top tbr_checker u_tbr_checker (.*);
